// File: src/csfr_pkg.sv
// ----------------------------------------------------------------------------
// csfr_pkg
// shared constants for the five-point cross smoothing filter with reflected
// borders: default sizes, register reset values and register indexes
// ----------------------------------------------------------------------------
package csfr_pkg;

    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int WIDTH_BITS      = 13;
    localparam int HEIGHT_BITS     = 16;
    localparam int ROW_BITS        = 17;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 1;

    localparam logic [WIDTH_BITS-1:0]  RST_FRAME_WIDTH  = 13'd640;
    localparam logic [HEIGHT_BITS-1:0] RST_FRAME_HEIGHT = 16'd480;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

endpackage

// File: src/cross_smoothing_filter_reflect_core.sv
// output: a result is in the output register in the cycle after the beat that
// completes it (pixel (r,c) completes with the beat for (r+1,c) or a drain beat)
// throughput: one beat per cycle unless output stalls (single-port row stores)
// reset: positions, handshake and output register clear; row stores keep
// their contents and need no clearing pass
// ----------------------------------------------------------------------------
// cross_smoothing_filter_reflect_core
// streamed (2*up + 2*down + 2*centre + left + right) smoothing filter, sum kept
// unscaled, with mirror borders, two line stores and an output register
// ----------------------------------------------------------------------------
module cross_smoothing_filter_reflect_core #(
    parameter int MAX_WIDTH   = csfr_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = csfr_pkg::SAMPLE_BITS_DEF,
    localparam int OUT_BITS   = SAMPLE_BITS + 3,
    localparam int IN_TDATA   = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA  = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [csfr_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [csfr_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    // input stream
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [IN_TDATA-1:0]                   i_s_axis_tdata,  // sample
    input  logic                                  i_s_axis_tuser,  // drain
    // output stream
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [OUT_TDATA-1:0]                  o_m_axis_tdata,  // filtered_value
    output logic                                  o_m_axis_tuser,  // sequence_error
    output logic                                  o_m_axis_tlast   // end_of_frame
);

    localparam int COL_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS  = csfr_pkg::ROW_BITS;
    localparam int WID_BITS  = csfr_pkg::WIDTH_BITS;
    localparam int HGT_BITS  = csfr_pkg::HEIGHT_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [OUT_BITS-1:0]    t_result;

    // configuration
    logic [WID_BITS-1:0]  r_frame_width,  n_frame_width;
    logic [HGT_BITS-1:0]  r_frame_height, n_frame_height;
    logic                 r_live;

    // position and window
    logic [COL_BITS-1:0]  r_col, n_col;
    logic [ROW_BITS-1:0]  r_row, n_row;
    t_sample              r_win_left, r_win_centre, r_first;

    // row stores
    t_sample              r_older_mem [MAX_WIDTH];
    t_sample              r_newer_mem [MAX_WIDTH];
    t_sample              r_older_q, r_newer_q;
    t_sample              r_older_fwd, r_newer_fwd;
    logic                 r_older_hit, r_newer_hit;

    // output register
    logic                 r_out_valid;
    t_result              r_out_value;
    logic                 r_out_last;
    logic                 r_out_err;

    logic [31:0]          w_eff, w_last32;
    logic [COL_BITS-1:0]  w_last;
    logic [HGT_BITS-1:0]  h_eff;
    logic                 cfg_acc, in_acc;
    logic                 drain_row, row0, col0, col_last, seq_err, produce;
    logic                 newer_we, older_we;
    logic [COL_BITS-1:0]  older_raddr, newer_raddr;
    t_sample              cur, older_v, newer_v;
    t_sample              left, centre, right, up, down;
    t_result              sum;
    logic [OUT_TDATA-1:0] out_tdata;

    // effective frame size
    always_comb begin
        if (r_frame_width < WID_BITS'(2)) begin
            w_eff = 32'd2;
        end else if ({{(32-WID_BITS){1'b0}}, r_frame_width} > 32'(MAX_WIDTH)) begin
            w_eff = 32'(MAX_WIDTH);
        end else begin
            w_eff = {{(32-WID_BITS){1'b0}}, r_frame_width};
        end
        w_last32 = w_eff - 32'd1;
        w_last   = w_last32[COL_BITS-1:0];
        h_eff    = (r_frame_height < HGT_BITS'(2)) ? HGT_BITS'(2) : r_frame_height;
    end

    assign o_cfg_ready     = r_live;
    assign o_s_axis_tready = r_live && (!r_out_valid || i_m_axis_tready);
    assign cfg_acc         = i_cfg_valid && o_cfg_ready;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // beat decode
    always_comb begin
        cur       = t_sample'(i_s_axis_tdata[SAMPLE_BITS-1:0]);
        drain_row = (r_row >= {1'b0, h_eff});
        row0      = (r_row == '0);
        col0      = (r_col == '0);
        col_last  = (r_col == w_last);
        seq_err   = i_s_axis_tuser ^ drain_row;
        produce   = in_acc && (!row0 || seq_err);
        newer_we  = in_acc && !drain_row;
        older_we  = in_acc && !drain_row && !row0;

        older_v   = r_older_hit ? r_older_fwd : r_older_q;
        newer_v   = r_newer_hit ? r_newer_fwd : r_newer_q;

        // mirrored left edge and right edge
        if (col0) begin
            centre = r_first;
            right  = newer_v;
            left   = newer_v;
        end else begin
            left   = r_win_left;
            centre = r_win_centre;
            right  = col_last ? r_win_left : newer_v;
        end

        if (drain_row) begin
            up   = older_v;
            down = older_v;
        end else begin
            up   = (r_row == ROW_BITS'(1)) ? cur : older_v;
            down = cur;
        end

        sum = (t_result'(up) <<< 1) + (t_result'(down) <<< 1)
            + (t_result'(centre) <<< 1) + t_result'(left) + t_result'(right);
    end

    // position and configuration update
    always_comb begin
        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        n_col          = r_col;
        n_row          = r_row;
        if (cfg_acc) begin
            case (i_cfg_index)
                csfr_pkg::CFG_FRAME_WIDTH: begin
                    n_frame_width = i_cfg_data[WID_BITS-1:0];
                    n_col         = '0;
                    n_row         = '0;
                end
                csfr_pkg::CFG_FRAME_HEIGHT: begin
                    n_frame_height = i_cfg_data[HGT_BITS-1:0];
                    n_col          = '0;
                    n_row          = '0;
                end
                default: begin
                end
            endcase
        end else if (in_acc) begin
            if (col_last) begin
                n_col = '0;
                n_row = drain_row ? '0 : r_row + ROW_BITS'(1);
            end else begin
                n_col = r_col + COL_BITS'(1);
            end
        end
        older_raddr = n_col;
        newer_raddr = n_col + COL_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live         <= 1'b0;
            r_frame_width  <= csfr_pkg::RST_FRAME_WIDTH;
            r_frame_height <= csfr_pkg::RST_FRAME_HEIGHT;
            r_col          <= '0;
            r_row          <= '0;
            r_older_hit    <= 1'b0;
            r_newer_hit    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_live         <= 1'b1;
            r_frame_width  <= n_frame_width;
            r_frame_height <= n_frame_height;
            r_col          <= n_col;
            r_row          <= n_row;
            r_older_hit    <= older_we && (r_col == older_raddr);
            r_newer_hit    <= newer_we && (r_col == newer_raddr);
            if (produce) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // row stores, registered reads at the position of the next beat to use them
    always_ff @(posedge i_clk) begin
        if (older_we) begin
            r_older_mem[r_col] <= centre;
        end
        if (newer_we) begin
            r_newer_mem[r_col] <= cur;
        end
        r_older_q   <= r_older_mem[older_raddr];
        r_newer_q   <= r_newer_mem[newer_raddr];
        r_older_fwd <= centre;
        r_newer_fwd <= cur;
    end

    // window, shadow of entry 0 and output payload
    always_ff @(posedge i_clk) begin
        if (newer_we && col0) begin
            r_first <= cur;
        end
        if (in_acc && !row0) begin
            r_win_left   <= centre;
            r_win_centre <= right;
        end
        if (produce) begin
            r_out_value <= row0 ? '0 : sum;
            r_out_last  <= !row0 && drain_row && col_last;
            r_out_err   <= seq_err;
        end
    end

    always_comb begin
        out_tdata                = '0;
        out_tdata[OUT_BITS-1:0]  = r_out_value;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = out_tdata;
    assign o_m_axis_tuser  = r_out_err;
    assign o_m_axis_tlast  = r_out_last;

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= {1'b0, h_eff})
        else $error("row position beyond drain row");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= w_last)
        else $error("column position beyond frame width");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !cfg_acc && drain_row && col_last |=> r_row == '0 && r_col == '0)
        else $error("frame did not restart after last drain beat");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !row0 |=> r_out_valid)
        else $error("beat past first row gave no result");

endmodule
